[hw/rtl/decimal_digit_interleave_codec_top_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef DECIMAL_DIGIT_INTERLEAVE_CODEC_TOP_ASSERT_SVH
`define DECIMAL_DIGIT_INTERLEAVE_CODEC_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDIC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ddic_pkg.sv]
`timescale 1ns / 1ps

package ddic_pkg;

    localparam int DIGITS      = 8;
    localparam int PACK_DIGITS = 2 * DIGITS;
    localparam int IN_W        = 32;
    localparam int VAL_W       = 27;
    localparam int PACK_W      = 54;
    localparam int BCD_W       = 4 * PACK_DIGITS;

    // Binary/BCD conversion steps done in one pipeline stage.
    localparam int STEP_BITS   = 8;
    localparam int VAL_STAGES  = (VAL_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PACK_STAGES = (PACK_W + STEP_BITS - 1) / STEP_BITS;
    localparam int NSTAGES     = 1 + VAL_STAGES + PACK_STAGES;

    localparam int TDATA_IN_W  = ((2 * IN_W + PACK_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((PACK_W + 2 * VAL_W + 7) / 8) * 8;

    localparam logic signed [IN_W-1:0] CLAMP_LOW  = -32'sd49999900;
    localparam logic signed [IN_W-1:0] CLAMP_HIGH = 32'sd50000000;
    localparam logic [VAL_W-1:0]       OFFSET     = 27'd49999900;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef logic [NSTAGES-1:0] stage_en_t;
    typedef logic [BCD_W-1:0]   bcd_t;

    // One double-dabble step: correct every digit of five or more, then shift a bit in.
    function automatic bcd_t bcd_shl(input bcd_t bcd, input logic bit_in);
        bcd_t r;
        r = bcd;
        for (int d = 0; d < PACK_DIGITS; d++) begin
            if (r[4*d +: 4] >= 4'd5) begin
                r[4*d +: 4] = r[4*d +: 4] + 4'd3;
            end
        end
        return {r[BCD_W-2:0], bit_in};
    endfunction

    // One reverse double-dabble step: halve the decimal value; the caller keeps bit 0.
    function automatic bcd_t bcd_shr(input bcd_t bcd);
        bcd_t r;
        r = bcd >> 1;
        for (int d = 0; d < PACK_DIGITS; d++) begin
            if (r[4*d +: 4] >= 4'd8) begin
                r[4*d +: 4] = r[4*d +: 4] - 4'd3;
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/ddic_enc_pipe.sv]
`timescale 1ns / 1ps

module ddic_enc_pipe (
    input  logic                         aclk,
    input  ddic_pkg::stage_en_t          load,
    input  logic signed [31:0]           dx_centi,
    input  logic signed [31:0]           dy_centi,
    output logic [ddic_pkg::PACK_W-1:0]  packed_out
);

    localparam int IN_W   = ddic_pkg::IN_W;
    localparam int VAL_W  = ddic_pkg::VAL_W;
    localparam int PACK_W = ddic_pkg::PACK_W;
    localparam int BCD_W  = ddic_pkg::BCD_W;
    localparam int STEP   = ddic_pkg::STEP_BITS;
    localparam int VS     = ddic_pkg::VAL_STAGES;
    localparam int PS     = ddic_pkg::PACK_STAGES;

    function automatic logic [VAL_W-1:0] bias(input logic signed [IN_W-1:0] v);
        logic signed [IN_W-1:0] c;
        c = v;
        if (v < ddic_pkg::CLAMP_LOW) begin
            c = ddic_pkg::CLAMP_LOW;
        end else if (v > ddic_pkg::CLAMP_HIGH) begin
            c = ddic_pkg::CLAMP_HIGH;
        end
        return VAL_W'(c + IN_W'(ddic_pkg::OFFSET));
    endfunction

    // x digits go to the odd decimal positions, y digits to the even ones.
    function automatic ddic_pkg::bcd_t interleave(input ddic_pkg::bcd_t xd,
                                                  input ddic_pkg::bcd_t yd);
        ddic_pkg::bcd_t r;
        r = '0;
        for (int j = 0; j < ddic_pkg::DIGITS; j++) begin
            r[8*j +: 4]     = yd[4*j +: 4];
            r[8*j + 4 +: 4] = xd[4*j +: 4];
        end
        return r;
    endfunction

    logic [VAL_W-1:0] xb_reg;
    logic [VAL_W-1:0] yb_reg;
    logic [VAL_W-1:0] xw_reg [0:VS-1];
    logic [VAL_W-1:0] yw_reg [0:VS-1];
    logic [BCD_W-1:0] xd_reg [0:VS-1];
    logic [BCD_W-1:0] yd_reg [0:VS-1];
    logic [BCD_W-1:0] pd_reg [0:PS-1];
    logic [PACK_W-1:0] pb_reg [0:PS-1];

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            xb_reg <= bias(dx_centi);
            yb_reg <= bias(dy_centi);
        end
    end

    // Binary to BCD, most significant bit first.
    for (genvar s = 0; s < VS; s++) begin : g_b2d
        localparam int FIRST = VAL_W - 1 - s * STEP;
        localparam int N     = (VAL_W - s * STEP < STEP) ? VAL_W - s * STEP : STEP;

        logic [VAL_W-1:0] xw_in;
        logic [VAL_W-1:0] yw_in;
        logic [BCD_W-1:0] xd_in;
        logic [BCD_W-1:0] yd_in;
        logic [BCD_W-1:0] xd_next;
        logic [BCD_W-1:0] yd_next;

        if (s == 0) begin : g_first
            assign xw_in = xb_reg;
            assign yw_in = yb_reg;
            assign xd_in = '0;
            assign yd_in = '0;
        end else begin : g_rest
            assign xw_in = xw_reg[s-1];
            assign yw_in = yw_reg[s-1];
            assign xd_in = xd_reg[s-1];
            assign yd_in = yd_reg[s-1];
        end

        always_comb begin
            xd_next = xd_in;
            yd_next = yd_in;
            for (int i = 0; i < N; i++) begin
                xd_next = ddic_pkg::bcd_shl(xd_next, xw_in[FIRST-i]);
                yd_next = ddic_pkg::bcd_shl(yd_next, yw_in[FIRST-i]);
            end
        end

        always_ff @(posedge aclk) begin
            if (load[1 + s]) begin
                xw_reg[s] <= xw_in;
                yw_reg[s] <= yw_in;
                xd_reg[s] <= xd_next;
                yd_reg[s] <= yd_next;
            end
        end
    end

    // Interleaved BCD back to binary, least significant bit first.
    for (genvar t = 0; t < PS; t++) begin : g_d2b
        localparam int N = (PACK_W - t * STEP < STEP) ? PACK_W - t * STEP : STEP;

        logic [BCD_W-1:0]  pd_in;
        logic [PACK_W-1:0] pb_in;
        logic [BCD_W-1:0]  pd_next;
        logic [PACK_W-1:0] pb_next;

        if (t == 0) begin : g_first
            assign pd_in = interleave(xd_reg[VS-1], yd_reg[VS-1]);
            assign pb_in = '0;
        end else begin : g_rest
            assign pd_in = pd_reg[t-1];
            assign pb_in = pb_reg[t-1];
        end

        always_comb begin
            pd_next = pd_in;
            pb_next = pb_in;
            for (int i = 0; i < N; i++) begin
                pb_next = {pd_next[0], pb_next[PACK_W-1:1]};
                pd_next = ddic_pkg::bcd_shr(pd_next);
            end
        end

        always_ff @(posedge aclk) begin
            if (load[1 + VS + t]) begin
                pd_reg[t] <= pd_next;
                pb_reg[t] <= pb_next;
            end
        end
    end

    assign packed_out = pb_reg[PS-1];

endmodule

[hw/rtl/ddic_dec_pipe.sv]
`timescale 1ns / 1ps

module ddic_dec_pipe (
    input  logic                              aclk,
    input  ddic_pkg::stage_en_t               load,
    input  logic [ddic_pkg::PACK_W-1:0]       packed_in,
    output logic signed [ddic_pkg::VAL_W-1:0] x_out_centi,
    output logic signed [ddic_pkg::VAL_W-1:0] y_out_centi
);

    localparam int VAL_W  = ddic_pkg::VAL_W;
    localparam int PACK_W = ddic_pkg::PACK_W;
    localparam int BCD_W  = ddic_pkg::BCD_W;
    localparam int STEP   = ddic_pkg::STEP_BITS;
    localparam int VS     = ddic_pkg::VAL_STAGES;
    localparam int PS     = ddic_pkg::PACK_STAGES;

    // Odd decimal positions carry x, even ones carry y.
    function automatic ddic_pkg::bcd_t pick_digits(input ddic_pkg::bcd_t pd,
                                                   input logic odd);
        ddic_pkg::bcd_t r;
        r = '0;
        for (int j = 0; j < ddic_pkg::DIGITS; j++) begin
            r[4*j +: 4] = odd ? pd[8*j + 4 +: 4] : pd[8*j +: 4];
        end
        return r;
    endfunction

    logic [PACK_W-1:0] pw_reg [0:PS-1];
    logic [BCD_W-1:0]  pd_reg [0:PS-1];
    logic [BCD_W-1:0]  xd_reg [0:VS-1];
    logic [BCD_W-1:0]  yd_reg [0:VS-1];
    logic [VAL_W-1:0]  xb_reg [0:VS-1];
    logic [VAL_W-1:0]  yb_reg [0:VS-1];
    logic signed [VAL_W-1:0] xo_reg;
    logic signed [VAL_W-1:0] yo_reg;

    // Binary to BCD. Carries out of the top digit are dropped, which keeps
    // only the low decimal digits of the packed word.
    for (genvar s = 0; s < PS; s++) begin : g_b2d
        localparam int FIRST = PACK_W - 1 - s * STEP;
        localparam int N     = (PACK_W - s * STEP < STEP) ? PACK_W - s * STEP : STEP;

        logic [PACK_W-1:0] pw_in;
        logic [BCD_W-1:0]  pd_in;
        logic [BCD_W-1:0]  pd_next;

        if (s == 0) begin : g_first
            assign pw_in = packed_in;
            assign pd_in = '0;
        end else begin : g_rest
            assign pw_in = pw_reg[s-1];
            assign pd_in = pd_reg[s-1];
        end

        always_comb begin
            pd_next = pd_in;
            for (int i = 0; i < N; i++) begin
                pd_next = ddic_pkg::bcd_shl(pd_next, pw_in[FIRST-i]);
            end
        end

        always_ff @(posedge aclk) begin
            if (load[s]) begin
                pw_reg[s] <= pw_in;
                pd_reg[s] <= pd_next;
            end
        end
    end

    // Each half back to binary, least significant bit first.
    for (genvar k = 0; k < VS; k++) begin : g_d2b
        localparam int N = (VAL_W - k * STEP < STEP) ? VAL_W - k * STEP : STEP;

        logic [BCD_W-1:0] xd_in;
        logic [BCD_W-1:0] yd_in;
        logic [VAL_W-1:0] xb_in;
        logic [VAL_W-1:0] yb_in;
        logic [BCD_W-1:0] xd_next;
        logic [BCD_W-1:0] yd_next;
        logic [VAL_W-1:0] xb_next;
        logic [VAL_W-1:0] yb_next;

        if (k == 0) begin : g_first
            assign xd_in = pick_digits(pd_reg[PS-1], 1'b1);
            assign yd_in = pick_digits(pd_reg[PS-1], 1'b0);
            assign xb_in = '0;
            assign yb_in = '0;
        end else begin : g_rest
            assign xd_in = xd_reg[k-1];
            assign yd_in = yd_reg[k-1];
            assign xb_in = xb_reg[k-1];
            assign yb_in = yb_reg[k-1];
        end

        always_comb begin
            xd_next = xd_in;
            yd_next = yd_in;
            xb_next = xb_in;
            yb_next = yb_in;
            for (int i = 0; i < N; i++) begin
                xb_next = {xd_next[0], xb_next[VAL_W-1:1]};
                yb_next = {yd_next[0], yb_next[VAL_W-1:1]};
                xd_next = ddic_pkg::bcd_shr(xd_next);
                yd_next = ddic_pkg::bcd_shr(yd_next);
            end
        end

        always_ff @(posedge aclk) begin
            if (load[PS + k]) begin
                xd_reg[k] <= xd_next;
                yd_reg[k] <= yd_next;
                xb_reg[k] <= xb_next;
                yb_reg[k] <= yb_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load[PS + VS]) begin
            xo_reg <= $signed(xb_reg[VS-1] - ddic_pkg::OFFSET);
            yo_reg <= $signed(yb_reg[VS-1] - ddic_pkg::OFFSET);
        end
    end

    assign x_out_centi = xo_reg;
    assign y_out_centi = yo_reg;

endmodule

[hw/rtl/decimal_digit_interleave_codec_top.sv]
`timescale 1ns / 1ps

// Decimal digit interleave codec.
// The input stream carries one transaction per item: s_tuser is the operation
// (0 encodes dx/dy into a 16-digit interleaved decimal number, 1 decodes
// packed_in back into x and y). Values are in hundredths; encode saturates
// them to [-49999900, 50000000] and adds 49999900 before interleaving.
// The result stream carries packed_out, x_out_centi and y_out_centi; the
// fields that the operation does not produce are zero.
// The datapath is a 12-stage pipeline. Encode clamps in one stage, then runs
// binary to BCD in 4 stages and BCD to binary in 7, 8 bits per stage. Decode
// runs binary to BCD in 7 stages and BCD to binary in 4, then subtracts the offset.
// One item per cycle is sustained while m_tready stays high.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and
// s_tready falls only once every stage holds an item.
// Reset clears all valid bits; the data and op registers are not reset.
module decimal_digit_interleave_codec_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // dx_centi [31:0], dy_centi [63:32], packed_in [117:64], zero fill [119:118]
    input  logic [ddic_pkg::TDATA_IN_W-1:0]     s_tdata,
    // op [0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // packed_out [53:0], x_out_centi [80:54], y_out_centi [107:81], zero fill [111:108]
    output logic [ddic_pkg::TDATA_OUT_W-1:0]    m_tdata
);

    localparam int IN_W   = ddic_pkg::IN_W;
    localparam int VAL_W  = ddic_pkg::VAL_W;
    localparam int PACK_W = ddic_pkg::PACK_W;
    localparam int NS     = ddic_pkg::NSTAGES;
    localparam int PAD_W  = ddic_pkg::TDATA_OUT_W - PACK_W - 2 * VAL_W;

    ddic_pkg::stage_en_t load;
    logic [NS-1:0]       v_reg;
    logic [NS-1:0]       v_next;
    ddic_pkg::op_t       op_reg [0:NS-1];

    logic [PACK_W-1:0]       enc_packed;
    logic signed [VAL_W-1:0] dec_x;
    logic signed [VAL_W-1:0] dec_y;

    // A stage takes new data when it is empty or its content moves on.
    always_comb begin
        load[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            load[k] = !v_reg[k] || load[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (!load[k]) begin
                v_next[k] = v_reg[k];
            end else if (k == 0) begin
                v_next[k] = s_tvalid;
            end else begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            op_reg[0] <= ddic_pkg::op_t'(s_tuser[0]);
        end
        for (int k = 1; k < NS; k++) begin
            if (load[k]) begin
                op_reg[k] <= op_reg[k-1];
            end
        end
    end

    ddic_enc_pipe u_enc (
        .aclk       (aclk),
        .load       (load),
        .dx_centi   ($signed(s_tdata[IN_W-1:0])),
        .dy_centi   ($signed(s_tdata[2*IN_W-1:IN_W])),
        .packed_out (enc_packed)
    );

    ddic_dec_pipe u_dec (
        .aclk        (aclk),
        .load        (load),
        .packed_in   (s_tdata[2*IN_W+PACK_W-1:2*IN_W]),
        .x_out_centi (dec_x),
        .y_out_centi (dec_y)
    );

    assign s_tready = load[0];
    assign m_tvalid = v_reg[NS-1];

    always_comb begin
        if (op_reg[NS-1] == ddic_pkg::OP_DECODE) begin
            m_tdata = {PAD_W'(0), dec_y, dec_x, PACK_W'(0)};
        end else begin
            m_tdata = {PAD_W'(0), VAL_W'(0), VAL_W'(0), enc_packed};
        end
    end

endmodule

[hw/rtl/ddic_port_checker.sv]
`timescale 1ns / 1ps
`include "decimal_digit_interleave_codec_top_assert.svh"

module ddic_port_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ddic_pkg::TDATA_OUT_W-1:0]  m_tdata
);

    // A stalled result must stay put.
    `DDIC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The input side only stalls when every stage is full and the output is blocked.
    `DDIC_ASSERT_SAME(a_in_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled with room in the pipeline")

    // Either the packed field or both decoded fields are zero.
    `DDIC_ASSERT_SAME(a_one_mode, aclk, aresetn, m_tvalid, (m_tdata[53:0] == 54'd0) || ((m_tdata[80:54] == 27'd0) && (m_tdata[107:81] == 27'd0)), "result mixes encode and decode fields")

    // Encoded numbers never exceed sixteen decimal digits.
    `DDIC_ASSERT_SAME(a_pack_range, aclk, aresetn, m_tvalid, m_tdata[53:0] <= 54'd9999999999999999, "packed result out of range")

    // Decoded x stays within its digit range less the offset.
    `DDIC_ASSERT_SAME(a_x_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[80:54]) >= -27'sd49999900) && ($signed(m_tdata[80:54]) <= 27'sd50000099), "decoded x out of range")

endmodule

bind decimal_digit_interleave_codec_top ddic_port_checker u_port_checker (.*);
